### src/pso_pkg.sv
`timescale 1ns / 1ps

package pso_pkg;

    localparam int PHASE_BITS_DEF  = 32;
    localparam int SINE_DEPTH_DEF  = 1024;

    localparam int FREQ_W  = 32;
    localparam int RATIO_W = 18;
    localparam int LEVEL_W = 17;
    localparam int SR_W    = 19;
    localparam int CFG_W   = 19;
    localparam int PROD_W  = 50;
    localparam int SAMP_W  = 17;

    localparam logic [16:0] LEVEL_QUIET = 17'd6;
    localparam logic [16:0] LEVEL_FULL  = 17'd65536;
    localparam logic signed [32:0] SQ_LIMIT = 33'sd39322;
    localparam logic signed [32:0] SQ_ONE   = 33'sd32768;
    localparam logic signed [32:0] Q30_ONE  = 33'sd1073741824;
    localparam logic signed [32:0] POLY_TOP = 33'sd172273;

    typedef enum logic [2:0] {
        CFG_ENABLE   = 3'd0,
        CFG_LEVEL    = 3'd1,
        CFG_WAVEFORM = 3'd2,
        CFG_RATIO    = 3'd3,
        CFG_SRATE    = 3'd4
    } cfg_index_t;

    // sine polynomial coefficients, Q30, Horner order
    function automatic logic signed [32:0] poly_coef(input logic [2:0] k);
        logic signed [32:0] c;
        case (k)
            3'd1:    c = -33'sd5026995;
            3'd2:    c = 33'sd85569306;
            3'd3:    c = -33'sd693598669;
            3'd4:    c = 33'sd1686629713;
            default: c = 33'sd0;
        endcase
        return c;
    endfunction

endpackage

### src/polyblep_sub_oscillator_top.sv
`timescale 1ns / 1ps
// Channel   Signals                                        Direction
// input     in_valid/in_ready, kind, base_frequency,       in
//           start_phase
// output    out_valid/out_ready, sample                    out
// config    cfg_we, cfg_addr, cfg_data                     in
//
// One item at a time; in_ready is high only when idle.
// Sine: increment divide, then six multiply steps; square: up to three
// divides on one shared restoring divider, one quotient bit per cycle.
// Note reset: no result. Quiet or disabled: zero result, straight from idle to output.
// Reset clears the phase and loads the register defaults.

module polyblep_sub_oscillator_top
    import pso_pkg::*;
#(
    parameter int PHASE_BITS       = PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      kind,
    input  logic [FREQ_W-1:0]         base_frequency,
    input  logic [31:0]               start_phase,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [SAMP_W-1:0]  sample,
    input  logic                      cfg_we,
    input  logic [2:0]                cfg_addr,
    input  logic [CFG_W-1:0]          cfg_data
);

    localparam int PB    = PHASE_BITS;
    localparam int DW    = (PB > SR_W) ? PB : SR_W;
    localparam int QW    = (PB > 32) ? PB - 1 : 31;
    localparam int CW    = $clog2(QW + 1);
    localparam int SHIFT = (PB > 32) ? PB - 32 : 0;
    localparam int SHR   = (PB < 32) ? 32 - PB : 0;
    localparam int LOG2D = $clog2(SINE_TABLE_DEPTH);
    localparam logic [PB-1:0] HALF = PB'(1) << (PB - 1);

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_FMUL   = 13'b0000000000010,
        ST_FDIV   = 13'b0000000000100,
        ST_FWAIT  = 13'b0000000001000,
        ST_SMUL   = 13'b0000000010000,
        ST_SACC   = 13'b0000000100000,
        ST_BSTART = 13'b0000001000000,
        ST_BWAIT  = 13'b0000010000000,
        ST_BMUL   = 13'b0000100000000,
        ST_BACC   = 13'b0001000000000,
        ST_LMUL   = 13'b0010000000000,
        ST_LFIN   = 13'b0100000000000,
        ST_OUT    = 13'b1000000000000
    } state_t;

    state_t state_reg;

    logic                enable_reg, waveform_reg;
    logic [LEVEL_W-1:0]  level_reg;
    logic [RATIO_W-1:0]  ratio_reg;
    logic [SR_W-1:0]     sr_reg;

    logic [PB-1:0]       phase_reg, dt_reg;
    logic [FREQ_W-1:0]   base_reg;
    logic signed [32:0]  acc_reg;
    logic signed [31:0]  x2_reg;
    logic [2:0]          step_reg;
    logic                bidx_reg, bneg_reg, half_reg;
    logic [16:0]         r_reg;
    logic signed [SAMP_W-1:0] out_reg;
    logic signed [65:0]  mul_reg;

    logic signed [32:0]  mul_a, mul_b;
    logic [SR_W-1:0]     sr_eff;
    logic [PROD_W-1:0]   prod_c;
    logic                is_half;
    logic [LOG2D-1:0]    idx;
    logic [29:0]         xq;
    logic [30:0]         xin;
    logic signed [35:0]  mq;
    logic signed [35:0]  pr;
    logic [15:0]         smag;
    logic [PB-1:0]       bt, bu;
    logic [PB:0]         one_m_dt;
    logic                c_lo, c_hi;
    logic [16:0]         bv;
    logic signed [32:0]  acc_cl;
    logic [16:0]         mag;
    logic [LEVEL_W-1:0]  lvl_eff;
    logic [16:0]         scaled;
    logic [QW:0]         dt_wide;
    logic [PB+31:0]      sp_wide;

    logic                div_start, div_done;
    logic [DW-1:0]       div_den, div_rem;
    logic [QW-1:0]       div_bits, div_quo;
    logic [CW-1:0]       div_cnt;

    function automatic logic signed [35:0] mulq(input logic signed [65:0] m);
        logic signed [65:0] adj;
        adj = m + (m[65] ? 66'sd1073741823 : 66'sd0);
        return 36'(adj >>> 30);
    endfunction

    always_comb
    begin
        sr_eff   = (sr_reg == '0) ? SR_W'(1) : sr_reg;
        prod_c   = (mul_reg[65:32] == '0) ? PROD_W'(64'h1_0000_0000) : mul_reg[PROD_W-1:0];
        is_half  = (prod_c[PROD_W-1:31] >= sr_eff);
        dt_wide  = {1'b0, div_quo} >> SHR;
        sp_wide  = {start_phase, PB'(0)};

        idx = phase_reg[PB-1 -: LOG2D];
        xq  = 30'(idx[LOG2D-3:0]) << (32 - LOG2D);
        xin = idx[LOG2D-2] ? (31'h4000_0000 - 31'(xq)) : 31'(xq);

        mq  = mulq(mul_reg);
        pr  = (mq < 36'sd0) ? 36'sd0 : ((mq > 36'(Q30_ONE)) ? 36'(Q30_ONE) : mq);
        smag = 16'((pr + 36'sd16384) >>> 15);

        bt       = bidx_reg ? PB'(phase_reg + HALF) : phase_reg;
        one_m_dt = (PB + 1)'(1) << PB;
        one_m_dt = one_m_dt - {1'b0, dt_reg};
        c_lo     = (dt_reg != '0) && (bt < dt_reg);
        c_hi     = (dt_reg != '0) && ({1'b0, bt} > one_m_dt);
        bu       = c_lo ? PB'(dt_reg - bt) : PB'(bt + dt_reg);
        bv       = 17'((mul_reg[33:0] + 34'd65536) >> 17);

        acc_cl  = (acc_reg > SQ_LIMIT) ? SQ_LIMIT :
                  ((acc_reg < -SQ_LIMIT) ? -SQ_LIMIT : acc_reg);
        mag     = acc_cl[32] ? 17'(-acc_cl) : 17'(acc_cl);
        lvl_eff = (level_reg > LEVEL_FULL) ? LEVEL_FULL : level_reg;
        scaled  = 17'((mul_reg[33:0] + 34'd32768) >> 16);

        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_FMUL:
            begin
                mul_a = 33'(base_reg);
                mul_b = 33'(ratio_reg);
            end
            ST_SMUL:
            begin
                if (step_reg == 3'd0)
                begin
                    mul_a = 33'(xin);
                    mul_b = 33'(xin);
                end
                else if (step_reg == 3'd5)
                begin
                    mul_a = acc_reg;
                    mul_b = 33'(xin);
                end
                else
                begin
                    mul_a = acc_reg;
                    mul_b = 33'(x2_reg);
                end
            end
            ST_BMUL:
            begin
                mul_a = 33'(r_reg);
                mul_b = 33'(r_reg);
            end
            ST_LMUL:
            begin
                mul_a = 33'(mag);
                mul_b = 33'(lvl_eff);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        div_start = 1'b0;
        div_den   = DW'(sr_eff);
        div_rem   = DW'(prod_c[PROD_W-1:31]);
        div_bits  = QW'(prod_c[30:0]) << SHIFT;
        div_cnt   = CW'(QW);
        if (state_reg == ST_FDIV)
        begin
            div_start = !is_half;
        end
        else if (state_reg == ST_BSTART)
        begin
            div_start = c_lo || c_hi;
            div_den   = DW'(dt_reg);
            div_rem   = DW'(bu >> 1);
            div_bits  = QW'({bu[0], 16'b0}) << (QW - 17);
            div_cnt   = CW'(17);
        end
    end

    pso_div #(
        .DW(DW),
        .QW(QW),
        .CW(CW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .den       (div_den),
        .rem_init  (div_rem),
        .bits_init (div_bits),
        .count     (div_cnt),
        .done      (div_done),
        .quo       (div_quo)
    );

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b0;
            level_reg    <= '0;
            waveform_reg <= 1'b0;
            ratio_reg    <= RATIO_W'(32768);
            sr_reg       <= SR_W'(48000);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_ENABLE:   enable_reg   <= cfg_data[0];
                CFG_LEVEL:    level_reg    <= cfg_data[LEVEL_W-1:0];
                CFG_WAVEFORM: waveform_reg <= cfg_data[0];
                CFG_RATIO:    ratio_reg    <= cfg_data[RATIO_W-1:0];
                CFG_SRATE:    sr_reg       <= cfg_data[SR_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= '0;
            step_reg  <= '0;
            bidx_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (kind)
                        begin
                            phase_reg <= sp_wide[PB+31:32];
                        end
                        else if (!enable_reg || level_reg <= LEVEL_QUIET)
                        begin
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            state_reg <= ST_FMUL;
                        end
                    end
                end
                ST_FMUL:  state_reg <= ST_FDIV;
                ST_FDIV:  state_reg <= ST_FWAIT;
                ST_FWAIT:
                begin
                    if (half_reg || div_done)
                    begin
                        step_reg  <= '0;
                        bidx_reg  <= 1'b0;
                        state_reg <= waveform_reg ? ST_BSTART : ST_SMUL;
                    end
                end
                ST_SMUL:  state_reg <= ST_SACC;
                ST_SACC:
                begin
                    step_reg  <= step_reg + 3'd1;
                    state_reg <= (step_reg == 3'd5) ? ST_LMUL : ST_SMUL;
                end
                ST_BSTART:
                begin
                    if (c_lo || c_hi)
                    begin
                        state_reg <= ST_BWAIT;
                    end
                    else if (!bidx_reg)
                    begin
                        bidx_reg <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= ST_LMUL;
                    end
                end
                ST_BWAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_BMUL;
                    end
                end
                ST_BMUL:  state_reg <= ST_BACC;
                ST_BACC:
                begin
                    bidx_reg  <= 1'b1;
                    state_reg <= bidx_reg ? ST_LMUL : ST_BSTART;
                end
                ST_LMUL:  state_reg <= ST_LFIN;
                ST_LFIN:
                begin
                    phase_reg <= PB'(phase_reg + dt_reg);
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                base_reg <= base_frequency;
                out_reg  <= '0;
            end
            ST_FDIV:
            begin
                half_reg <= is_half;
            end
            ST_FWAIT:
            begin
                dt_reg  <= half_reg ? HALF : dt_wide[PB-1:0];
                acc_reg <= waveform_reg ? (phase_reg[PB-1] ? -SQ_ONE : SQ_ONE) : POLY_TOP;
            end
            ST_SACC:
            begin
                if (step_reg == 3'd0)
                begin
                    x2_reg <= mq[31:0];
                end
                else if (step_reg == 3'd5)
                begin
                    acc_reg <= idx[LOG2D-1] ? -33'(smag) : 33'(smag);
                end
                else
                begin
                    acc_reg <= poly_coef(step_reg) + 33'(mq);
                end
            end
            ST_BSTART:
            begin
                bneg_reg <= c_lo ^ bidx_reg;
            end
            ST_BWAIT:
            begin
                r_reg <= div_quo[16:0];
            end
            ST_BACC:
            begin
                acc_reg <= bneg_reg ? (acc_reg - 33'(bv)) : (acc_reg + 33'(bv));
            end
            ST_LFIN:
            begin
                out_reg <= acc_reg[32] ? SAMP_W'(-scaled) : SAMP_W'(scaled);
            end
            default:  ;
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign sample    = out_reg;

endmodule

### src/pso_div.sv
`timescale 1ns / 1ps

module pso_div
    import pso_pkg::*;
#(
    parameter int DW = 32,
    parameter int QW = 31,
    parameter int CW = $clog2(QW + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] den,
    input  logic [DW-1:0] rem_init,
    input  logic [QW-1:0] bits_init,
    input  logic [CW-1:0] count,
    output logic          done,
    output logic [QW-1:0] quo
);

    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] den_reg;
    logic [QW-1:0] bits_reg;
    logic [QW-1:0] quo_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   rem_sh;
    logic          ge;

    always_comb
    begin
        rem_sh   = {rem_reg, bits_reg[QW-1]};
        ge       = (rem_sh >= {1'b0, den_reg});
        rem_next = ge ? DW'(rem_sh - {1'b0, den_reg}) : rem_sh[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= count;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= rem_init;
            den_reg  <= den;
            bits_reg <= bits_init;
            quo_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            bits_reg <= bits_reg << 1;
            quo_reg  <= {quo_reg[QW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule
